// ===== rtl/rpu_pkg.sv =====
// Package for the packed raw pixel unpacker: width modes, register indexes,
// group descriptor type and the bit selection functions that unpack a group.
// No dependencies.
`default_nettype none
package rpu_pkg;

	localparam int GROUP_DEPTH = 10;
	localparam int PHASE_W     = $clog2(GROUP_DEPTH);
	localparam int PIX_W       = 16;
	localparam int CFG_DW      = 15;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [1:0] MODE_8  = 2'd0;
	localparam logic [1:0] MODE_10 = 2'd1;
	localparam logic [1:0] MODE_12 = 2'd2;
	localparam logic [1:0] MODE_16 = 2'd3;

	localparam logic REG_BITS_MODE  = 1'b0;
	localparam logic REG_ROW_PIXELS = 1'b1;

	typedef logic [GROUP_DEPTH-1:0][7:0] grp_bytes_t;

	// One complete packing group, handed from front to back.
	typedef struct packed {
		grp_bytes_t bytes;
		logic [1:0] mode;
	} grp_t;

	// Bytes per group for a width mode.
	function automatic logic [PHASE_W-1:0] grp_len(input logic [1:0] mode);
		logic [PHASE_W-1:0] n;
		unique case (mode)
			MODE_8:  n = PHASE_W'(1);
			MODE_10: n = PHASE_W'(10);
			MODE_12: n = PHASE_W'(6);
			default: n = PHASE_W'(2);
		endcase
		return n;
	endfunction

	// Index of the last pixel in a group for a width mode.
	function automatic logic [2:0] grp_last_idx(input logic [1:0] mode);
		logic [2:0] n;
		unique case (mode)
			MODE_10: n = 3'd7;
			MODE_12: n = 3'd3;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [9:0] unpack10(input grp_bytes_t b, input logic [2:0] k);
		logic [9:0] v;
		unique case (k)
			3'd0:    v = {b[1], b[0][7:6]};
			3'd1:    v = {b[0][5:0], b[3][7:4]};
			3'd2:    v = {b[3][3:0], b[2][7:2]};
			3'd3:    v = {b[2][1:0], b[5]};
			3'd4:    v = {b[4], b[7][7:6]};
			3'd5:    v = {b[7][5:0], b[6][7:4]};
			3'd6:    v = {b[6][3:0], b[9][7:2]};
			default: v = {b[9][1:0], b[8]};
		endcase
		return v;
	endfunction

	function automatic logic [11:0] unpack12(input grp_bytes_t b, input logic [1:0] k);
		logic [11:0] v;
		unique case (k)
			2'd0:    v = {b[1], b[0][7:4]};
			2'd1:    v = {b[0][3:0], b[3]};
			2'd2:    v = {b[2], b[5][7:4]};
			default: v = {b[5][3:0], b[4]};
		endcase
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] pixel_of(input grp_bytes_t b, input logic [1:0] mode,
			input logic [2:0] k);
		logic [PIX_W-1:0] v;
		unique case (mode)
			MODE_8:  v = PIX_W'(b[0]);
			MODE_10: v = PIX_W'(unpack10(b, k));
			MODE_12: v = PIX_W'(unpack12(b, k[1:0]));
			default: v = {b[1], b[0]};
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rpu_front.sv =====
// Front end of the unpacker: accepts bytes, collects one packing group and
// pushes the complete group into the queue. Depends on rpu_pkg.
`default_nettype none
module rpu_front import rpu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] mode,
	input  wire logic       phase_clr,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       q_full,
	output logic            q_push,
	output grp_t            q_entry
);

	grp_bytes_t         bytes_q;
	logic [PHASE_W-1:0] phase_q;
	grp_bytes_t         group;
	logic               accept;
	logic               complete;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign complete = (phase_q + PHASE_W'(1)) == grp_len(mode);
	assign q_push   = accept && complete;

	// Merge the arriving byte so a finished group leaves this cycle.
	always_comb begin
		group          = bytes_q;
		group[phase_q] = data_byte;
	end

	assign q_entry.bytes = group;
	assign q_entry.mode  = mode;

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q[phase_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (phase_clr) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= complete ? '0 : phase_q + PHASE_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rpu_fifo.sv =====
// Short group queue between front and back end, flip-flop storage.
// Depends on rpu_pkg (grp_t, QDEPTH).
`default_nettype none
module rpu_fifo import rpu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  grp_t      wr_entry,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output grp_t      head
);

	grp_t           entries_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full      = cnt_q == (QAW+1)'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Depth is a power of two: pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rpu_back.sv =====
// Back end of the unpacker (depends on rpu_pkg): walks the head group's
// pixels one per cycle unless stalled; tracks row column, drives output register.
`default_nettype none
module rpu_back import rpu_pkg::*; #(
	parameter int MAX_ROW_PIXELS = 16384,
	localparam int CW = $clog2(MAX_ROW_PIXELS),
	localparam int RW = CW + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          col_clr,
	input  wire logic [RW-1:0] row_width,
	input  wire logic          q_valid,
	input  grp_t               q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [PIX_W-1:0]   pixel_value,
	output logic               group_last,
	output logic               row_end
);

	logic [2:0]    k_q;
	logic [CW-1:0] col_q;
	logic          out_valid_q;
	logic          load;
	logic          last_pix;
	logic [RW-1:0] col_next;
	logic          row_last;

	assign load     = q_valid && (!out_valid_q || out_ready);
	assign last_pix = k_q == grp_last_idx(q_head.mode);
	assign col_next = {1'b0, col_q} + RW'(1);
	assign row_last = col_next >= row_width;
	assign q_pop    = load && last_pix;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_value <= pixel_of(q_head.bytes, q_head.mode, k_q);
			group_last  <= last_pix;
			row_end     <= row_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= last_pix ? 3'd0 : k_q + 3'd1;
			end
			if (col_clr) begin
				col_q <= '0;
			end else if (load) begin
				col_q <= row_last ? '0 : col_next[CW-1:0];
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/packed_raw_pixel_unpacker_top.sv =====
// Packed raw pixel unpacker. Bytes of a packed raw sensor stream enter one
// per cycle on the input channel while the queue is not full; every
// completed packing group (1 byte in 8-bit mode, 10 bytes = 8 pixels in
// 10-bit mode, 6 bytes = 4 pixels in 12-bit mode, 2 bytes = 1 little-endian
// pixel in 16-bit mode) is queued and its pixels leave one per cycle while
// out_ready allows, right aligned, with group_last on the last pixel of the
// group and row_end on the last pixel of each row. The first pixel of a
// group passes through the queue and then the output register before it is
// valid on the output. Write the registers only while no request is in
// flight: a bits_mode write drops any partial group and restarts the row, a
// row_pixels write restarts the row.
// Row widths above MAX_ROW_PIXELS are clamped to it; zero flags every pixel.
// Depends on rpu_pkg, rpu_front, rpu_fifo, rpu_back.
`default_nettype none
module packed_raw_pixel_unpacker_top import rpu_pkg::*; #(
	parameter int MAX_ROW_PIXELS = 16384
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [PIX_W-1:0]       pixel_value,
	output logic                   group_last,
	output logic                   row_end
);

	localparam int CW = $clog2(MAX_ROW_PIXELS);
	localparam int RW = CW + 1;
	// Compare width wide enough for both the register and the clamp limit.
	localparam int LW = (RW > CFG_DW) ? RW : CFG_DW;
	localparam int RESET_WIDTH = (3336 > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : 3336;
	localparam logic [LW-1:0] MAX_L = LW'(MAX_ROW_PIXELS);

	logic [1:0]    bits_mode_q;
	logic [RW-1:0] row_width_q;
	logic [LW-1:0] width_wr;
	logic          mode_wr;
	logic          col_clr;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	grp_t q_entry;
	grp_t q_head;

	// Register writes: a mode write restarts the group and the row, any
	// row width write restarts the row.
	assign mode_wr  = cfg_we && (cfg_index == REG_BITS_MODE);
	assign col_clr  = cfg_we;
	assign width_wr = LW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_mode_q <= MODE_10;
			row_width_q <= RW'(RESET_WIDTH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BITS_MODE: begin
					bits_mode_q <= cfg_data[1:0];
				end
				default: begin
					// Clamp the row width at write time.
					row_width_q <= (width_wr > MAX_L) ? RW'(MAX_ROW_PIXELS)
						: RW'(width_wr);
				end
			endcase
		end
	end

	// Front: accept bytes and assemble groups.
	rpu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (bits_mode_q),
		.phase_clr (mode_wr),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	// Queue: decouple group assembly from pixel emission.
	rpu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (q_entry),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Back: emit pixels one per cycle unless out_ready stalls, and mark row ends.
	rpu_back #(
		.MAX_ROW_PIXELS (MAX_ROW_PIXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_clr     (col_clr),
		.row_width   (row_width_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_value (pixel_value),
		.group_last  (group_last),
		.row_end     (row_end)
	);

`ifndef NO_ASSERTIONS
	// Retiring a group must present its last pixel in the next cycle.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid && group_last))
		else $error("group retired without a last pixel on the output");

	// The output only becomes valid from a queued group.
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_valid))
		else $error("output valid rose with an empty queue");
`endif

endmodule
`default_nettype wire
